// ----- design/rv32im_instruction_execute_core_defines.svh -----
// assertion macros used by the checker file
`ifndef RV32IM_INSTRUCTION_EXECUTE_CORE_DEFINES_SVH
`define RV32IM_INSTRUCTION_EXECUTE_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define RV32IE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rv32ie check failed");

// antecedent implies consequent in the next cycle
`define RV32IE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rv32ie check failed");

`endif

// ----- design/rv32ie_pkg.sv -----
// ----------------------------------------------------------------------------
// rv32ie_pkg
// types and constants shared by the rv32im execute core
// ----------------------------------------------------------------------------
`default_nettype none

package rv32ie_pkg;

  localparam logic [31:0] RESET_ADDR  = 32'h8000_0000;
  localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;

  // data window size in bytes; a power of two so the window offset is a bit slice
  localparam int DMEM_BYTES = 4096;

  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_ALUI   = 7'h13;
  localparam logic [6:0] OPC_ALU    = 7'h33;
  localparam logic [6:0] OPC_BRANCH = 7'h63;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [6:0] F7_MULD = 7'h01;

  localparam logic [4:0] REG_A0 = 5'd10;

  typedef enum logic [0:0] {
    CFG_BOOT = 1'b0,
    CFG_BASE = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_HALT = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    OP_LUI, OP_AUIPC, OP_JAL, OP_JALR, OP_LOAD, OP_STORE, OP_ALUI, OP_ALU,
    OP_MUL, OP_DIV, OP_BRANCH, OP_EBREAK, OP_BAD
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_MUL, S_DIV, S_MEM, S_MRD, S_DONE
  } state_t;

  typedef struct packed {
    op_t         op;
    logic [2:0]  f3;
    logic        alt;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
  } dec_t;

  typedef struct packed {
    logic        boot_we;
    logic [31:0] boot;
    logic [31:0] base;
  } cfg_t;

  typedef struct packed {
    logic [31:0] exec_pc;
    logic [31:0] next_pc;
    logic        dest_write;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    status_t     status;
    logic [31:0] exit_code;
  } res_t;

endpackage

`default_nettype wire

// ----- design/rv32ie_ram.sv -----
// ----------------------------------------------------------------------------
// rv32ie_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module rv32ie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ----- design/rv32ie_front.sv -----
// ----------------------------------------------------------------------------
// rv32ie_front
// two-entry instruction queue with decode of the oldest entry
// ----------------------------------------------------------------------------
`default_nettype none

module rv32ie_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [31:0]       instr,
  output logic                   full,
  output logic                   dec_valid,
  output rv32ie_pkg::dec_t       dec,
  input  wire logic              dec_take
);

  logic [31:0] q_r [2];
  logic        wptr_r, rptr_r;
  logic [1:0]  cnt_r;
  logic        do_push, do_pop;
  logic [31:0] i;
  logic [6:0]  f7;
  logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;

  assign full      = (cnt_r == 2'd2);
  assign dec_valid = (cnt_r != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = dec_take && dec_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_push) wptr_r <= !wptr_r;
      if (do_pop)  rptr_r <= !rptr_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q_r[wptr_r] <= instr;
  end

  assign i     = q_r[rptr_r];
  assign f7    = i[31:25];
  assign imm_i = {{20{i[31]}}, i[31:20]};
  assign imm_s = {{20{i[31]}}, i[31:25], i[11:7]};
  assign imm_b = {{19{i[31]}}, i[31], i[7], i[30:25], i[11:8], 1'b0};
  assign imm_j = {{11{i[31]}}, i[31], i[19:12], i[20], i[30:21], 1'b0};
  assign imm_u = {i[31:12], 12'b0};

  always_comb begin
    dec.f3  = i[14:12];
    dec.rd  = i[11:7];
    dec.rs1 = i[19:15];
    dec.rs2 = i[24:20];
    dec.alt = 1'b0;
    dec.imm = imm_i;
    dec.op  = rv32ie_pkg::OP_BAD;
    unique case (i[6:0])
      rv32ie_pkg::OPC_LUI: begin
        dec.op = rv32ie_pkg::OP_LUI; dec.imm = imm_u;
      end
      rv32ie_pkg::OPC_AUIPC: begin
        dec.op = rv32ie_pkg::OP_AUIPC; dec.imm = imm_u;
      end
      rv32ie_pkg::OPC_JAL: begin
        dec.op = rv32ie_pkg::OP_JAL; dec.imm = imm_j;
      end
      rv32ie_pkg::OPC_JALR: begin
        if (i[14:12] == 3'd0) dec.op = rv32ie_pkg::OP_JALR;
      end
      rv32ie_pkg::OPC_LOAD: begin
        if (i[14:12] inside {3'd0, 3'd1, 3'd2, 3'd4, 3'd5}) dec.op = rv32ie_pkg::OP_LOAD;
      end
      rv32ie_pkg::OPC_STORE: begin
        dec.imm = imm_s;
        if (i[14:12] inside {3'd0, 3'd1, 3'd2}) dec.op = rv32ie_pkg::OP_STORE;
      end
      rv32ie_pkg::OPC_ALUI: begin
        case (i[14:12])
          3'd1: if (f7 == rv32ie_pkg::F7_BASE) dec.op = rv32ie_pkg::OP_ALUI;
          3'd5: begin
            if (f7 == rv32ie_pkg::F7_BASE || f7 == rv32ie_pkg::F7_ALT) begin
              dec.op  = rv32ie_pkg::OP_ALUI;
              dec.alt = (f7 == rv32ie_pkg::F7_ALT);
            end
          end
          3'd2: dec.op = rv32ie_pkg::OP_BAD;
          default: dec.op = rv32ie_pkg::OP_ALUI;
        endcase
      end
      rv32ie_pkg::OPC_ALU: begin
        if (f7 == rv32ie_pkg::F7_BASE) begin
          dec.op = rv32ie_pkg::OP_ALU;
        end else if (f7 == rv32ie_pkg::F7_ALT &&
                     (i[14:12] == 3'd0 || i[14:12] == 3'd5)) begin
          dec.op  = rv32ie_pkg::OP_ALU;
          dec.alt = 1'b1;
        end else if (f7 == rv32ie_pkg::F7_MULD) begin
          if (i[14]) dec.op = rv32ie_pkg::OP_DIV;
          else if (i[14:12] != 3'd2) dec.op = rv32ie_pkg::OP_MUL;
        end
      end
      rv32ie_pkg::OPC_BRANCH: begin
        dec.imm = imm_b;
        if (i[14:13] != 2'b01) dec.op = rv32ie_pkg::OP_BRANCH;
      end
      default: begin
        if (i == rv32ie_pkg::EBREAK_WORD) begin
          dec.op  = rv32ie_pkg::OP_EBREAK;
          dec.rs1 = rv32ie_pkg::REG_A0;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/rv32ie_div.sv -----
// ----------------------------------------------------------------------------
// rv32ie_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rv32ie_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quot,
  output logic [31:0]      rem
);

  logic [31:0] rem_r, quo_r, dvs_r;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r;
  logic [32:0] sh, diff;

  assign sh   = {rem_r, quo_r[31]};
  assign diff = sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= 32'd0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      // a clear borrow means the trial subtraction fits
      rem_r <= diff[32] ? sh[31:0] : diff[31:0];
      quo_r <= {quo_r[30:0], !diff[32]};
    end
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// ----- design/rv32ie_back.sv -----
// ----------------------------------------------------------------------------
// rv32ie_back
// execute sequencer: register file, alu, multiplier, divider, data memory
// ----------------------------------------------------------------------------
`default_nettype none

module rv32ie_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              dec_valid,
  input  wire rv32ie_pkg::dec_t  dec,
  output logic                   dec_take,
  input  wire rv32ie_pkg::cfg_t  cfg,
  output logic                   res_valid,
  output rv32ie_pkg::res_t       res,
  input  wire logic              res_ready
);

  localparam int IDXW = $clog2(rv32ie_pkg::DMEM_BYTES);

  rv32ie_pkg::state_t  state_r, state_nxt;
  rv32ie_pkg::dec_t    dec_r;
  rv32ie_pkg::status_t st_r, st_nxt;
  logic [31:0] pc_r;
  logic [31:0] opa_r, opa_nxt, opb_r, opb_nxt;
  logic [31:0] val_r, val_nxt, npc_r, npc_nxt, ex_r, ex_nxt, ld_r, ld_nxt;
  logic        wr_r, wr_nxt;
  logic [63:0] prod_r;
  logic [IDXW-1:0] off_r, off_nxt;
  logic [IDXW:0]   off_inc;
  logic [1:0]  cnt_r, cnt_nxt, nlast;
  logic [31:0] vld_r;
  logic        va_r, vb_r;
  logic [31:0] qa, qb, a, b, b2, alu, addr, moff;
  logic [4:0]  sh;
  logic        taken, commit, rf_we, mem_we, last, sgn;
  logic [7:0]  mem_q, mem_wd;
  logic        div_start, div_done;
  logic [31:0] div_dnd, div_dvs, div_q, div_r;

  rv32ie_ram #(.WIDTH(32), .DEPTH(32)) u_rfa (
    .clk(clk), .we(rf_we), .waddr(dec_r.rd), .wdata(val_r),
    .raddr(dec.rs1), .rdata(qa)
  );
  rv32ie_ram #(.WIDTH(32), .DEPTH(32)) u_rfb (
    .clk(clk), .we(rf_we), .waddr(dec_r.rd), .wdata(val_r),
    .raddr(dec.rs2), .rdata(qb)
  );
  rv32ie_ram #(.WIDTH(8), .DEPTH(rv32ie_pkg::DMEM_BYTES)) u_dmem (
    .clk(clk), .we(mem_we), .waddr(off_r), .wdata(mem_wd),
    .raddr(off_r), .rdata(mem_q)
  );
  rv32ie_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dnd),
    .divisor(div_dvs), .done(div_done), .quot(div_q), .rem(div_r)
  );

  // registers never written read as zero
  always_ff @(posedge clk) begin
    va_r <= vld_r[dec.rs1];
    vb_r <= vld_r[dec.rs2];
  end
  assign a = va_r ? qa : 32'd0;
  assign b = vb_r ? qb : 32'd0;

  assign dec_take = (state_r == rv32ie_pkg::S_IDLE) && dec_valid;
  assign commit   = (state_r == rv32ie_pkg::S_DONE) && res_ready;
  assign rf_we    = commit && wr_r && (dec_r.rd != 5'd0);

  assign b2 = (dec_r.op == rv32ie_pkg::OP_ALU) ? b : dec_r.imm;
  assign sh = b2[4:0];
  always_comb begin
    case (dec_r.f3)
      3'd0:    alu = dec_r.alt ? a - b2 : a + b2;
      3'd1:    alu = a << sh;
      3'd2:    alu = {31'd0, $signed(a) < $signed(b2)};
      3'd3:    alu = {31'd0, a < b2};
      3'd4:    alu = a ^ b2;
      3'd5:    alu = dec_r.alt ? $unsigned($signed(a) >>> sh) : a >> sh;
      3'd6:    alu = a | b2;
      default: alu = a & b2;
    endcase
    case (dec_r.f3)
      3'd0:    taken = (a == b);
      3'd1:    taken = (a != b);
      3'd4:    taken = $signed(a) < $signed(b);
      3'd5:    taken = $signed(a) >= $signed(b);
      3'd6:    taken = a < b;
      3'd7:    taken = a >= b;
      default: taken = 1'b0;
    endcase
  end

  assign addr  = a + dec_r.imm;
  // window offset wraps at the window size
  assign moff  = addr - cfg.base;
  assign sgn   = !dec_r.f3[0];
  assign nlast = (dec_r.f3[1:0] == 2'd0) ? 2'd0 : (dec_r.f3[1:0] == 2'd1) ? 2'd1 : 2'd3;
  assign last  = (cnt_r == nlast);
  assign off_inc = {1'b0, off_r} + {{IDXW{1'b0}}, 1'b1};
  assign mem_wd  = 8'(opb_r >> {cnt_r, 3'b000});
  assign mem_we  = (state_r == rv32ie_pkg::S_MEM) && (dec_r.op == rv32ie_pkg::OP_STORE);
  assign ld_nxt  = ld_r | ({24'd0, mem_q} << {cnt_r, 3'b000});

  assign div_start = (state_r == rv32ie_pkg::S_EXEC) && (dec_r.op == rv32ie_pkg::OP_DIV);
  assign div_dnd   = (sgn && a[31]) ? 32'd0 - a : a;
  assign div_dvs   = (sgn && b[31]) ? 32'd0 - b : b;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rv32ie_pkg::S_IDLE: if (dec_valid) state_nxt = rv32ie_pkg::S_EXEC;
      rv32ie_pkg::S_EXEC: begin
        case (dec_r.op)
          rv32ie_pkg::OP_MUL: state_nxt = rv32ie_pkg::S_MUL;
          rv32ie_pkg::OP_DIV: state_nxt = rv32ie_pkg::S_DIV;
          rv32ie_pkg::OP_LOAD, rv32ie_pkg::OP_STORE: state_nxt = rv32ie_pkg::S_MEM;
          default: state_nxt = rv32ie_pkg::S_DONE;
        endcase
      end
      rv32ie_pkg::S_MUL:  state_nxt = rv32ie_pkg::S_DONE;
      rv32ie_pkg::S_DIV:  if (div_done) state_nxt = rv32ie_pkg::S_DONE;
      rv32ie_pkg::S_MEM: begin
        if (dec_r.op == rv32ie_pkg::OP_LOAD) state_nxt = rv32ie_pkg::S_MRD;
        else if (last) state_nxt = rv32ie_pkg::S_DONE;
      end
      rv32ie_pkg::S_MRD:  state_nxt = last ? rv32ie_pkg::S_DONE : rv32ie_pkg::S_MEM;
      rv32ie_pkg::S_DONE: if (res_ready) state_nxt = rv32ie_pkg::S_IDLE;
      default: state_nxt = rv32ie_pkg::S_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    opa_nxt = opa_r;
    opb_nxt = opb_r;
    val_nxt = val_r;
    npc_nxt = npc_r;
    wr_nxt  = wr_r;
    st_nxt  = st_r;
    ex_nxt  = ex_r;
    off_nxt = off_r;
    cnt_nxt = cnt_r;
    unique case (state_r)
      rv32ie_pkg::S_EXEC: begin
        opa_nxt = a;
        opb_nxt = b;
        npc_nxt = pc_r + 32'd4;
        val_nxt = 32'd0;
        wr_nxt  = 1'b0;
        st_nxt  = rv32ie_pkg::ST_OK;
        ex_nxt  = 32'd0;
        case (dec_r.op)
          rv32ie_pkg::OP_LUI:   begin val_nxt = dec_r.imm; wr_nxt = 1'b1; end
          rv32ie_pkg::OP_AUIPC: begin val_nxt = pc_r + dec_r.imm; wr_nxt = 1'b1; end
          rv32ie_pkg::OP_JAL: begin
            val_nxt = pc_r + 32'd4; wr_nxt = 1'b1; npc_nxt = pc_r + dec_r.imm;
          end
          rv32ie_pkg::OP_JALR: begin
            val_nxt = pc_r + 32'd4; wr_nxt = 1'b1; npc_nxt = addr & ~32'd1;
          end
          rv32ie_pkg::OP_LOAD, rv32ie_pkg::OP_STORE: begin
            off_nxt = moff[IDXW-1:0];
            cnt_nxt = 2'd0;
          end
          rv32ie_pkg::OP_ALUI, rv32ie_pkg::OP_ALU: begin val_nxt = alu; wr_nxt = 1'b1; end
          rv32ie_pkg::OP_BRANCH: if (taken) npc_nxt = pc_r + dec_r.imm;
          rv32ie_pkg::OP_EBREAK: begin st_nxt = rv32ie_pkg::ST_HALT; ex_nxt = a; end
          rv32ie_pkg::OP_BAD:    st_nxt = rv32ie_pkg::ST_BAD;
          default: ;
        endcase
      end
      rv32ie_pkg::S_MUL: begin
        wr_nxt = 1'b1;
        case (dec_r.f3)
          3'd0:    val_nxt = prod_r[31:0];
          3'd3:    val_nxt = prod_r[63:32];
          default: val_nxt = prod_r[63:32] - (opa_r[31] ? opb_r : 32'd0)
                             - (opb_r[31] ? opa_r : 32'd0);
        endcase
      end
      rv32ie_pkg::S_DIV: begin
        wr_nxt = 1'b1;
        case (dec_r.f3[1:0])
          2'd0: val_nxt = ((opa_r[31] ^ opb_r[31]) && (opb_r != 32'd0)) ?
                          32'd0 - div_q : div_q;
          2'd1: val_nxt = div_q;
          2'd2: val_nxt = opa_r[31] ? 32'd0 - div_r : div_r;
          default: val_nxt = div_r;
        endcase
      end
      rv32ie_pkg::S_MEM: begin
        if (dec_r.op == rv32ie_pkg::OP_STORE && !last) begin
          cnt_nxt = cnt_r + 2'd1;
          off_nxt = (off_inc == (IDXW+1)'(rv32ie_pkg::DMEM_BYTES)) ? '0 : off_inc[IDXW-1:0];
        end
      end
      rv32ie_pkg::S_MRD: begin
        if (last) begin
          wr_nxt = 1'b1;
          case (dec_r.f3)
            3'd0:    val_nxt = {{24{ld_nxt[7]}}, ld_nxt[7:0]};
            3'd1:    val_nxt = {{16{ld_nxt[15]}}, ld_nxt[15:0]};
            3'd4:    val_nxt = {24'd0, ld_nxt[7:0]};
            3'd5:    val_nxt = {16'd0, ld_nxt[15:0]};
            default: val_nxt = ld_nxt;
          endcase
        end else begin
          cnt_nxt = cnt_r + 2'd1;
          off_nxt = (off_inc == (IDXW+1)'(rv32ie_pkg::DMEM_BYTES)) ? '0 : off_inc[IDXW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rv32ie_pkg::S_IDLE;
      pc_r    <= rv32ie_pkg::RESET_ADDR;
      vld_r   <= 32'd0;
    end else begin
      state_r <= state_nxt;
      if (cfg.boot_we) pc_r <= cfg.boot;
      else if (commit) pc_r <= npc_r;
      if (rf_we) vld_r[dec_r.rd] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_take) dec_r <= dec;
    opa_r  <= opa_nxt;
    opb_r  <= opb_nxt;
    val_r  <= val_nxt;
    npc_r  <= npc_nxt;
    wr_r   <= wr_nxt;
    st_r   <= st_nxt;
    ex_r   <= ex_nxt;
    off_r  <= off_nxt;
    cnt_r  <= cnt_nxt;
    prod_r <= {32'd0, a} * {32'd0, b};
    if (state_r == rv32ie_pkg::S_EXEC) ld_r <= 32'd0;
    else if (state_r == rv32ie_pkg::S_MRD) ld_r <= ld_nxt;
  end

  assign res_valid = (state_r == rv32ie_pkg::S_DONE);
  always_comb begin
    res.exec_pc    = pc_r;
    res.next_pc    = npc_r;
    res.dest_write = wr_r && (dec_r.rd != 5'd0);
    res.dest_index = res.dest_write ? dec_r.rd : 5'd0;
    res.dest_value = res.dest_write ? val_r : 32'd0;
    res.status     = st_r;
    res.exit_code  = ex_r;
  end

endmodule

`default_nettype wire

// ----- design/rv32im_instruction_execute_core.sv -----
// ----------------------------------------------------------------------------
// rv32im_instruction_execute_core
// single-issue rv32im execute core with queue-style channels
// ----------------------------------------------------------------------------
// usage:
//   in channel: push an instruction word fetched at the current pc while full
//   is low; a two-entry queue holds words ahead of the executor.
//   out channel: one result per instruction, in order; read it while empty is
//   low and pop it. the result sits in an output register, so the executor
//   goes on with the next instruction while it waits; it stalls only when it
//   has a new result and the register is still full.
//   cfg channel: index 0 sets the boot pc (and the current pc), index 1 the
//   data window base; ready is always high.
//   execution: alu, jump, branch and system ops go from exec straight to the
//   result; multiply adds a product stage, divide waits on the radix-2
//   divider, and loads and stores access the 4096-byte window one byte at a
//   time, with a registered read on loads.
//   one instruction is in execution at a time; the next is accepted only
//   after the result is handed to the output register.
//   reset: pc to 0x80000000, base to 0x80000000, registers read zero, queues
//   empty. data memory content is undefined until stored.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32im_instruction_execute_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  input  wire logic [31:0] in_instruction,
  output logic             in_full,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [31:0]      out_exec_pc,
  output logic [31:0]      out_next_pc,
  output logic             out_dest_write,
  output logic [4:0]       out_dest_index,
  output logic [31:0]      out_dest_value,
  output logic [1:0]       out_status,
  output logic [31:0]      out_exit_code,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic              dec_valid, dec_take, res_valid, res_ready, out_valid_r;
  rv32ie_pkg::dec_t  dec;
  rv32ie_pkg::cfg_t  cfg;
  rv32ie_pkg::res_t  res, out_r;
  logic [31:0]       base_r;
  logic              cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= rv32ie_pkg::RESET_ADDR;
    end else if (cfg_we && cfg_index == rv32ie_pkg::CFG_BASE) begin
      base_r <= cfg_data;
    end
  end

  assign cfg.boot_we = cfg_we && (cfg_index == rv32ie_pkg::CFG_BOOT);
  assign cfg.boot    = cfg_data;
  assign cfg.base    = base_r;

  rv32ie_front u_front (
    .clk(clk), .rst_n(rst_n), .push(in_push), .instr(in_instruction),
    .full(in_full), .dec_valid(dec_valid), .dec(dec), .dec_take(dec_take)
  );

  rv32ie_back u_back (
    .clk(clk), .rst_n(rst_n), .dec_valid(dec_valid), .dec(dec), .dec_take(dec_take),
    .cfg(cfg), .res_valid(res_valid), .res(res), .res_ready(res_ready)
  );

  // output register takes a new result when free or being popped
  assign res_ready = !out_valid_r || out_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) out_r <= res;
  end

  assign out_empty      = !out_valid_r;
  assign out_exec_pc    = out_r.exec_pc;
  assign out_next_pc    = out_r.next_pc;
  assign out_dest_write = out_r.dest_write;
  assign out_dest_index = out_r.dest_index;
  assign out_dest_value = out_r.dest_value;
  assign out_status     = out_r.status;
  assign out_exit_code  = out_r.exit_code;

endmodule

`default_nettype wire

// ----- design/rv32ie_checker.sv -----
// ----------------------------------------------------------------------------
// rv32ie_checker
// port-level checks on the result channel of the execute core
// ----------------------------------------------------------------------------
`default_nettype none
`include "rv32im_instruction_execute_core_defines.svh"

module rv32ie_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic [31:0] out_exec_pc,
  input wire logic [31:0] out_next_pc,
  input wire logic        out_dest_write,
  input wire logic [4:0]  out_dest_index,
  input wire logic [31:0] out_dest_value,
  input wire logic [1:0]  out_status,
  input wire logic [31:0] out_exit_code
);

  // a waiting result stays put until popped
  `RV32IE_ASSERT_NXT(a_hold, !out_empty && !out_pop, !out_empty && $stable(out_exec_pc))

  // no register write means zero index and value
  `RV32IE_ASSERT_IMP(a_nowr, !out_empty && !out_dest_write, out_dest_index == 5'd0 && out_dest_value == 32'd0)

  // exit code only on halt
  `RV32IE_ASSERT_IMP(a_exit, !out_empty && out_status != rv32ie_pkg::ST_HALT, out_exit_code == 32'd0)

  // an invalid instruction writes nothing and falls through
  `RV32IE_ASSERT_IMP(a_bad, !out_empty && out_status == rv32ie_pkg::ST_BAD, !out_dest_write && out_next_pc == out_exec_pc + 32'd4)

endmodule

bind rv32im_instruction_execute_core rv32ie_checker u_rv32ie_checker (.*);

`default_nettype wire
